### rtl/cat_pkg.sv
package cat_pkg;

    localparam int DIV_STEPS   = 60;
    localparam int SQRT_STEPS  = 30;
    localparam int ST_DIV0     = 3;
    localparam int ST_SQ0      = ST_DIV0 + DIV_STEPS;
    localparam int ST_B1       = ST_SQ0 + SQRT_STEPS;
    localparam int NUM_STAGES  = ST_B1 + 5;
    localparam int ST_OUT      = NUM_STAGES - 1;

    localparam int ROLL_SHIFT  = 73;
    localparam int BODY_SHIFT  = 77;

    localparam logic [30:0]        ROLL_GAIN_RST = 31'd10296;
    localparam logic signed [31:0] BODY_GAIN_RST = -32'sd2714973;
    localparam logic [30:0]        SINE_ONE      = 31'h4000_0000;

    typedef enum logic [0:0] {
        CFG_ROLL_GAIN = 1'b0,
        CFG_BODY_GAIN = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic neg_x;
        logic vz_neg;
        logic vy_pos;
    } t_flags;

    typedef struct packed {
        logic [46:0] x2;
        logic [46:0] y2;
        logic [46:0] z2;
        logic [15:0] rho;
        logic [30:0] lcca;
        t_flags      fl;
    } t_f1;

    typedef struct packed {
        logic [47:0] sum;
        logic [47:0] dxy;
        logic [47:0] dxz;
        logic [46:0] y2;
        logic [46:0] z2;
        logic [15:0] rho;
        logic [60:0] coef;
        t_flags      fl;
    } t_f2;

    typedef struct packed {
        logic [63:0] p;
        logic [60:0] coef;
        t_flags      fl;
    } t_side;

    typedef struct packed {
        logic [48:0] rem;
        logic [59:0] quo;
        logic [47:0] den;
        logic        full;
        logic        zero;
    } t_div_lane;

    typedef struct packed {
        logic [59:0] x;
        logic [58:0] r;
        logic        full;
        logic        zero;
    } t_sq_lane;

    typedef struct packed {
        t_div_lane a;
        t_div_lane b;
        t_side     s;
    } t_dstg;

    typedef struct packed {
        t_sq_lane a;
        t_sq_lane b;
        t_side    s;
    } t_sstg;

    typedef struct packed {
        logic [2:0][63:0] op;
        logic [63:0]      p;
        logic [2:0]       neg;
    } t_b1;

    typedef struct packed {
        logic [2:0][63:0] ll;
        logic [2:0][63:0] lh;
        logic [2:0][63:0] hl;
        logic [2:0][63:0] hh;
        logic [2:0]       neg;
    } t_m1;

    typedef struct packed {
        logic [2:0][63:0] ll;
        logic [2:0][64:0] mid;
        logic [2:0][63:0] hh;
        logic [2:0]       neg;
    } t_m2;

    typedef struct packed {
        logic [2:0][127:0] prod;
        logic [2:0]        neg;
    } t_m3;

    function automatic t_div_lane div_init(logic [46:0] n2, logic [47:0] d);
        t_div_lane o;
        o.rem  = {2'b0, n2};
        o.quo  = '0;
        o.den  = d;
        o.zero = (d == 48'd0);
        o.full = ({1'b0, n2} >= d) && (d != 48'd0);
        return o;
    endfunction

    // one restoring step: one quotient bit
    function automatic t_div_lane div_step(t_div_lane l);
        logic [48:0] t;
        logic        ge;
        t_div_lane   o;
        o     = l;
        t     = {l.rem[47:0], 1'b0};
        ge    = (t >= {1'b0, l.den});
        o.rem = ge ? (t - {1'b0, l.den}) : t;
        o.quo = {l.quo[58:0], ge};
        return o;
    endfunction

    function automatic t_sq_lane sq_init(t_div_lane l);
        t_sq_lane o;
        o.x    = l.quo;
        o.r    = '0;
        o.full = l.full;
        o.zero = l.zero;
        return o;
    endfunction

    // one digit of the square root; j selects the bit pair
    function automatic t_sq_lane sq_step(t_sq_lane l, int j);
        logic [59:0] bitv;
        logic [59:0] cand;
        t_sq_lane    o;
        o    = l;
        bitv = 60'd1 << (58 - 2 * j);
        cand = {1'b0, l.r} + bitv;
        if (l.x >= cand) begin
            o.x = l.x - cand;
            o.r = {1'b0, l.r[58:1]} + bitv[58:0];
        end else begin
            o.r = {1'b0, l.r[58:1]};
        end
        return o;
    endfunction

    function automatic logic [30:0] sine_mag(t_sq_lane l);
        logic [30:0] s;
        if (l.zero) begin
            s = '0;
        end else if (l.full) begin
            s = SINE_ONE;
        end else begin
            s = l.r[30:0];
        end
        return s;
    endfunction

    // round half away from zero, apply sign, clamp to 32 bits
    function automatic logic [31:0] round_sat(logic [127:0] prod, int sh, logic neg);
        logic [127:0] m;
        logic [31:0]  o;
        m = (prod + (128'd1 << (sh - 1))) >> sh;
        if (neg) begin
            if (m > 128'h8000_0000) begin
                o = 32'h8000_0000;
            end else begin
                o = 32'd0 - m[31:0];
            end
        end else begin
            if (m > 128'h7FFF_FFFF) begin
                o = 32'h7FFF_FFFF;
            end else begin
                o = m[31:0];
            end
        end
        return o;
    endfunction

endpackage

### rtl/cat_in_if.sv
interface cat_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] vel_z;
    logic [15:0]        air_density;
    logic signed [15:0] lift_coeff;
    logic signed [15:0] canard_angle;

    modport source (
        output valid, vel_x, vel_y, vel_z, air_density, lift_coeff, canard_angle,
        input  ready
    );
    modport sink (
        input  valid, vel_x, vel_y, vel_z, air_density, lift_coeff, canard_angle,
        output ready
    );
endinterface

### rtl/cat_out_if.sv
interface cat_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;

    modport source (
        output valid, torque_x, torque_y, torque_z,
        input  ready
    );
    modport sink (
        input  valid, torque_x, torque_y, torque_z,
        output ready
    );
endinterface

### rtl/canard_aero_torque.sv
// Each item passes through NUM_STAGES register stages from item accept to result valid.
// Throughput: one item per cycle while no result sits unclaimed; the divider (60 stages) and root (30 stages)
//   are fully unrolled, one quotient bit or root digit per stage.
// The pipeline moves as a whole: it stalls only while a result sits unclaimed.
// Reset (synchronous, active low) clears all valid bits and loads the gain
//   registers with their defaults; payload registers are not reset.
module canard_aero_torque import cat_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cat_in_if.sink    i_in,
    cat_out_if.source o_out,
    input  logic      i_cfg_we,
    input  t_cfg_idx  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // gain registers
    logic [30:0]        r_roll_gain;
    logic signed [31:0] r_body_gain;

    // valid bit per stage, bit 0 is the first stage
    logic [NUM_STAGES-1:0] r_vld;
    logic                  en;

    // front end
    t_f1   n_f1, r_f1;
    t_f2   n_f2, r_f2;
    t_dstg n_f3, r_f3;

    // divider and root stages
    t_dstg r_dv [DIV_STEPS];
    t_sstg r_sq [SQRT_STEPS];

    // back end: sines, wide products, rounding
    t_b1 n_b1, r_b1;
    t_m1 n_m1, r_m1;
    t_m2 n_m2, r_m2;
    t_m3 n_m3, r_m3;
    logic [31:0] n_tx, n_ty, n_tz;
    logic [31:0] r_tx, r_ty, r_tz;

    logic [23:0] ax, ay, az;
    logic [15:0] mlc, mca;
    logic [31:0] gmag;
    logic        gneg;
    logic [30:0] sa, sb;

    // whole pipe advances unless the result register is held
    assign en         = !r_vld[ST_OUT] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_gain <= ROLL_GAIN_RST;
            r_body_gain <= BODY_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROLL_GAIN: r_roll_gain <= i_cfg_data[30:0];
                CFG_BODY_GAIN: r_body_gain <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_in.valid};
        end
    end

    // stage 1: magnitudes and squares
    always_comb begin
        ax  = i_in.vel_x[23] ? (24'd0 - i_in.vel_x) : i_in.vel_x;
        ay  = i_in.vel_y[23] ? (24'd0 - i_in.vel_y) : i_in.vel_y;
        az  = i_in.vel_z[23] ? (24'd0 - i_in.vel_z) : i_in.vel_z;
        mlc = i_in.lift_coeff[15] ? (16'd0 - i_in.lift_coeff) : i_in.lift_coeff;
        mca = i_in.canard_angle[15] ? (16'd0 - i_in.canard_angle) : i_in.canard_angle;
        n_f1.x2        = 47'({24'd0, ax} * {24'd0, ax});
        n_f1.y2        = 47'({24'd0, ay} * {24'd0, ay});
        n_f1.z2        = 47'({24'd0, az} * {24'd0, az});
        n_f1.rho       = i_in.air_density;
        n_f1.lcca      = 31'({16'd0, mlc} * {16'd0, mca});
        n_f1.fl.neg_x  = i_in.lift_coeff[15] ^ i_in.canard_angle[15];
        n_f1.fl.vz_neg = i_in.vel_z[23];
        n_f1.fl.vy_pos = !i_in.vel_y[23] && (i_in.vel_y != 24'sd0);
    end

    // stage 2: sums of squares, roll coefficient
    always_comb begin
        n_f2.sum  = {1'b0, r_f1.x2} + {1'b0, r_f1.y2} + {1'b0, r_f1.z2};
        n_f2.dxy  = {1'b0, r_f1.x2} + {1'b0, r_f1.y2};
        n_f2.dxz  = {1'b0, r_f1.x2} + {1'b0, r_f1.z2};
        n_f2.y2   = r_f1.y2;
        n_f2.z2   = r_f1.z2;
        n_f2.rho  = r_f1.rho;
        n_f2.coef = 61'({31'd0, r_f1.lcca} * {31'd0, r_roll_gain});
        n_f2.fl   = r_f1.fl;
    end

    // stage 3: dynamic pressure (raw, weight 2^-31), divider setup
    always_comb begin
        n_f3.s.p    = {48'd0, r_f2.rho} * {16'd0, r_f2.sum};
        n_f3.s.coef = r_f2.coef;
        n_f3.s.fl   = r_f2.fl;
        n_f3.a      = div_init(r_f2.z2, r_f2.dxz);
        n_f3.b      = div_init(r_f2.y2, r_f2.dxy);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1 <= n_f1;
            r_f2 <= n_f2;
            r_f3 <= n_f3;
        end
    end

    // n2 * 2^60 / d, one bit per stage, both angles side by side
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv[k].a <= div_step(r_f3.a);
                    r_dv[k].b <= div_step(r_f3.b);
                    r_dv[k].s <= r_f3.s;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv[k].a <= div_step(r_dv[k-1].a);
                    r_dv[k].b <= div_step(r_dv[k-1].b);
                    r_dv[k].s <= r_dv[k-1].s;
                end
            end
        end
    end

    // integer square root of the quotient, one digit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq[k].a <= sq_step(sq_init(r_dv[DIV_STEPS-1].a), k);
                    r_sq[k].b <= sq_step(sq_init(r_dv[DIV_STEPS-1].b), k);
                    r_sq[k].s <= r_dv[DIV_STEPS-1].s;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq[k].a <= sq_step(r_sq[k-1].a, k);
                    r_sq[k].b <= sq_step(r_sq[k-1].b, k);
                    r_sq[k].s <= r_sq[k-1].s;
                end
            end
        end
    end

    // sines (Q30, special cases folded in) times |body_gain|
    always_comb begin
        gneg = r_body_gain[31];
        gmag = gneg ? (32'd0 - r_body_gain) : r_body_gain;
        sa   = sine_mag(r_sq[SQRT_STEPS-1].a);
        sb   = sine_mag(r_sq[SQRT_STEPS-1].b);
        n_b1.op[0]  = {3'd0, r_sq[SQRT_STEPS-1].s.coef};
        n_b1.op[1]  = {32'd0, gmag} * {33'd0, sa};
        n_b1.op[2]  = {32'd0, gmag} * {33'd0, sb};
        n_b1.p      = r_sq[SQRT_STEPS-1].s.p;
        n_b1.neg[0] = r_sq[SQRT_STEPS-1].s.fl.neg_x;
        n_b1.neg[1] = gneg ^ r_sq[SQRT_STEPS-1].s.fl.vz_neg;
        n_b1.neg[2] = gneg ^ r_sq[SQRT_STEPS-1].s.fl.vy_pos;
    end

    // 64x64 products as four 32x32 partials each
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_m1.ll[i] = {32'd0, r_b1.op[i][31:0]}  * {32'd0, r_b1.p[31:0]};
            n_m1.lh[i] = {32'd0, r_b1.op[i][31:0]}  * {32'd0, r_b1.p[63:32]};
            n_m1.hl[i] = {32'd0, r_b1.op[i][63:32]} * {32'd0, r_b1.p[31:0]};
            n_m1.hh[i] = {32'd0, r_b1.op[i][63:32]} * {32'd0, r_b1.p[63:32]};
        end
        n_m1.neg = r_b1.neg;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_m2.ll[i]  = r_m1.ll[i];
            n_m2.hh[i]  = r_m1.hh[i];
            n_m2.mid[i] = {1'b0, r_m1.lh[i]} + {1'b0, r_m1.hl[i]};
        end
        n_m2.neg = r_m1.neg;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_m3.prod[i] = {r_m2.hh[i], 64'd0} + {31'd0, r_m2.mid[i], 32'd0}
                         + {64'd0, r_m2.ll[i]};
        end
        n_m3.neg = r_m2.neg;
    end

    always_comb begin
        n_tx = round_sat(r_m3.prod[0], ROLL_SHIFT, r_m3.neg[0]);
        n_ty = round_sat(r_m3.prod[1], BODY_SHIFT, r_m3.neg[1]);
        n_tz = round_sat(r_m3.prod[2], BODY_SHIFT, r_m3.neg[2]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1 <= n_b1;
            r_m1 <= n_m1;
            r_m2 <= n_m2;
            r_m3 <= n_m3;
            r_tx <= n_tx;
            r_ty <= n_ty;
            r_tz <= n_tz;
        end
    end

    assign o_out.valid    = r_vld[ST_OUT];
    assign o_out.torque_x = r_tx;
    assign o_out.torque_y = r_ty;
    assign o_out.torque_z = r_tz;

endmodule

### rtl/cat_chk.sv
module cat_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_torque_x,
    input logic [31:0] i_torque_y,
    input logic [31:0] i_torque_z
);

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // nothing held at the output: input side must be open
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with output empty");

    // held result freezes the pipe
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while pipe is frozen");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_torque_x)
            && $stable(i_torque_y) && $stable(i_torque_z))
        else $error("stalled result changed");

endmodule

bind canard_aero_torque cat_chk u_cat_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_torque_x  (o_out.torque_x),
    .i_torque_y  (o_out.torque_y),
    .i_torque_z  (o_out.torque_z)
);

### test/canard_aero_torque_tb.sv
`timescale 1ns / 1ps

module canard_aero_torque_tb;
    import cat_pkg::*;

    // one input item as the block sees it
    typedef struct {
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic signed [23:0] vel_z;
        logic [15:0]        air_density;
        logic signed [15:0] lift_coeff;
        logic signed [15:0] canard_angle;
    } t_sample;

    // one torque triple
    typedef struct {
        logic [31:0] tx;
        logic [31:0] ty;
        logic [31:0] tz;
    } t_torque;

    // Torque predictor plus the queue of torques still owed by the block.
    class torque_board;
        logic [30:0]        roll_gain;
        logic signed [31:0] body_gain;
        t_torque            owed[$];
        int                 mismatches;

        function void set_gain(t_cfg_idx idx, logic [31:0] data);
            if (idx == CFG_ROLL_GAIN) begin
                roll_gain = data[30:0];
            end else begin
                body_gain = data;
            end
        endfunction

        // sine magnitude in Q30: sqrt(n2/d), zero when d is zero
        function bit [30:0] sine_q30(bit [63:0] n2, bit [63:0] d);
            bit [127:0] q;
            bit [63:0]  r;
            if (d == 0) return '0;
            if (n2 >= d) return 31'h4000_0000;
            q = ({64'd0, n2} << 60) / {64'd0, d};
            r = 0;
            for (int i = 29; i >= 0; i--) begin
                if ((({64'd0, r | (64'd1 << i)}) * ({64'd0, r | (64'd1 << i)})) <= q) begin
                    r = r | (64'd1 << i);
                end
            end
            return r[30:0];
        endfunction

        // round half away from zero by 2^sh, sign, clamp to 32 bits
        function logic [31:0] to_q8(bit [127:0] prod, int sh, bit neg);
            bit [127:0] m;
            m = (prod + (128'd1 << (sh - 1))) >> sh;
            if (neg) begin
                if (m > 128'h8000_0000) return 32'h8000_0000;
                return 32'd0 - m[31:0];
            end
            if (m > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
            return m[31:0];
        endfunction

        function void note_sample(t_sample s);
            longint          vx, vy, vz, lc, ca, bg;
            longint unsigned x2, y2, z2, p, coef, gmag;
            bit [30:0]       sa, sb;
            t_torque         t;
            vx = s.vel_x;  vy = s.vel_y;  vz = s.vel_z;
            lc = s.lift_coeff;  ca = s.canard_angle;  bg = body_gain;
            x2 = vx * vx;  y2 = vy * vy;  z2 = vz * vz;
            p = longint'(s.air_density) * (x2 + y2 + z2);
            coef = longint'(lc < 0 ? -lc : lc) * longint'(ca < 0 ? -ca : ca)
                   * longint'(roll_gain);
            t.tx = to_q8({64'd0, coef} * {64'd0, p}, ROLL_SHIFT, (lc < 0) != (ca < 0));
            gmag = bg < 0 ? -bg : bg;
            sa = sine_q30(z2, x2 + z2);
            sb = sine_q30(y2, x2 + y2);
            t.ty = to_q8({64'd0, gmag * sa} * {64'd0, p}, BODY_SHIFT, (bg < 0) != (vz < 0));
            t.tz = to_q8({64'd0, gmag * sb} * {64'd0, p}, BODY_SHIFT, (bg < 0) != (vy > 0));
            owed.push_back(t);
        endfunction

        function void check_torque(t_torque got);
            t_torque want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h %h %h",
                                               got.tx, got.ty, got.tz);
                return;
            end
            want = owed.pop_front();
            if (got.tx !== want.tx || got.ty !== want.ty || got.tz !== want.tz) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("torque mismatch: exp %h %h %h got %h %h %h",
                             want.tx, want.ty, want.tz, got.tx, got.ty, got.tz);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [31:0] i_cfg_data;

    cat_in_if  in_ch();
    cat_out_if out_ch();

    canard_aero_torque DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    torque_board board = new();

    // pipeline depth plus margin, for drain before config writes and at end
    localparam int DRAIN_CYCLES = NUM_STAGES + 20;

    bit no_idle;       // when set, neither side inserts gaps
    bit hold_request;  // asks the receiver for one long hold-off

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Receiver: random stalls, one long hold-off on request.
    initial begin
        int stall;
        t_torque got;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (hold_request) begin
                hold_request = 1'b0;
                stall = 400;   // long enough to back the whole pipe up
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got.tx = out_ch.torque_x;
            got.ty = out_ch.torque_y;
            got.tz = out_ch.torque_z;
            board.check_torque(got);
        end
    end

    // Offer one item after a random gap; valid stays high across back-to-back items.
    task automatic send_sample(t_sample s);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.vel_x        <= s.vel_x;
        in_ch.vel_y        <= s.vel_y;
        in_ch.vel_z        <= s.vel_z;
        in_ch.air_density  <= s.air_density;
        in_ch.lift_coeff   <= s.lift_coeff;
        in_ch.canard_angle <= s.canard_angle;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_sample(s);
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every torque is back, then let the pipe drain.
    task automatic drain();
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one write, then the enable goes low again before the task returns
    task automatic write_gain(t_cfg_idx idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board.set_gain(idx, data);
        @(posedge i_clk);
    endtask

    // Velocity mix: mostly full range, also small, zero and the extremes.
    function automatic logic signed [23:0] pick_vel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 24'sh80_0000;
            2:       return 24'sh7F_FFFF;
            3, 4:    return 24'($signed($urandom_range(0, 4000)) - 2000);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_q16();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h8000;
            2:       return 16'h7FFF;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_sample make_sample(logic signed [23:0] vx, logic signed [23:0] vy,
                                            logic signed [23:0] vz, logic [15:0] rho,
                                            logic signed [15:0] lc, logic signed [15:0] ca);
        t_sample s;
        s.vel_x = vx;  s.vel_y = vy;  s.vel_z = vz;
        s.air_density = rho;  s.lift_coeff = lc;  s.canard_angle = ca;
        return s;
    endfunction

    task automatic send_random(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_sample(make_sample(pick_vel(), pick_vel(), pick_vel(),
                                    pick_q16(), pick_q16(), pick_q16()));
        end
        no_idle = 1'b0;
        stop_sending();
    endtask

    // Directed corners: zero speed (both sines zero), axial flight,
    // pure side or vertical flow (unit sine), field extremes, clamp cases.
    task automatic send_corners();
        send_sample(make_sample(0, 0, 0, 16'hFFFF, 16'sh7FFF, 16'sh7FFF));
        send_sample(make_sample(24'sd2560, 0, 0, 16'd20070, 16'sd410, 16'sd1638));
        send_sample(make_sample(0, 24'sd2560, 0, 16'd20070, -16'sd410, 16'sd1638));
        send_sample(make_sample(0, -24'sd2560, 0, 16'd20070, 16'sd410, -16'sd1638));
        send_sample(make_sample(0, 0, 24'sd2560, 16'd20070, -16'sd410, -16'sd1638));
        send_sample(make_sample(0, 0, -24'sd2560, 16'd20070, 16'sd1, 16'sd1));
        send_sample(make_sample(24'sd25600, 24'sd1280, -24'sd1280, 16'd20070,
                                16'sd2048, 16'sd800));
        send_sample(make_sample(-24'sd25600, -24'sd700, 24'sd900, 16'd16384,
                                -16'sd2048, 16'sd800));
        send_sample(make_sample(24'sh7F_FFFF, 24'sh7F_FFFF, 24'sh7F_FFFF, 16'hFFFF,
                                16'sh7FFF, 16'sh7FFF));
        send_sample(make_sample(24'sh80_0000, 24'sh80_0000, 24'sh80_0000, 16'hFFFF,
                                16'sh8000, 16'sh7FFF));
        send_sample(make_sample(24'sh80_0000, 24'sh7F_FFFF, 24'sh80_0000, 16'hFFFF,
                                16'sh8000, 16'sh8000));
        send_sample(make_sample(24'sh7F_FFFF, 0, 24'sh80_0000, 0, 16'sh8000, 16'sh8000));
        send_sample(make_sample(24'sd1, 24'sd1, 24'sd1, 16'd1, 16'sd1, -16'sd1));
        send_sample(make_sample(-24'sd1, 24'sd0, 24'sd1, 16'hFFFF, 0, 16'sh7FFF));
        send_sample(make_sample(24'sd3, -24'sd4, 24'sd4, 16'd1, 16'sh7FFF, 0));
        send_sample(make_sample(24'sh55_5555, 24'shAA_AAAA, 24'sh33_3333, 16'hA5A5,
                                16'sh5A5A, -16'sh5A5A));
        stop_sending();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_ROLL_GAIN;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.vel_x  = '0;
        in_ch.vel_y  = '0;
        in_ch.vel_z  = '0;
        in_ch.air_density  = '0;
        in_ch.lift_coeff   = '0;
        in_ch.canard_angle = '0;
        no_idle      = 1'b0;
        hold_request = 1'b0;
        board.roll_gain = ROLL_GAIN_RST;
        board.body_gain = BODY_GAIN_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset gains
        send_corners();
        hold_request = 1'b1;
        send_random(450);
        drain();

        // zero roll, most negative body gain
        write_gain(CFG_ROLL_GAIN, 32'd0);
        write_gain(CFG_BODY_GAIN, 32'h8000_0000);
        send_random(450);
        drain();

        // both gains at their maximum
        write_gain(CFG_ROLL_GAIN, 32'h7FFF_FFFF);
        write_gain(CFG_BODY_GAIN, 32'h7FFF_FFFF);
        send_corners();
        send_random(430);
        drain();

        // random gains
        write_gain(CFG_ROLL_GAIN, $urandom);
        write_gain(CFG_BODY_GAIN, $urandom);
        send_random(450);
        drain();

        if (board.mismatches == 0 && board.owed.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

### files.f
rtl/cat_pkg.sv
rtl/cat_in_if.sv
rtl/cat_out_if.sv
rtl/canard_aero_torque.sv
rtl/cat_chk.sv
test/canard_aero_torque_tb.sv
